FILE: rtl/core/page_table_walk_map_unmap_assert.svh
// assertion macros shared by the page table walker modules
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef PAGE_TABLE_WALK_MAP_UNMAP_ASSERT_SVH
`define PAGE_TABLE_WALK_MAP_UNMAP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PTW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/ptw_pkg.sv
// types and constants for the page table walker
// no dependencies
`timescale 1ns / 1ps
package ptw_pkg;
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BADARG    = 3'd1;
	localparam logic [2:0] ST_ALREADY   = 3'd2;
	localparam logic [2:0] ST_NOTMAPPED = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_MAP    = 2'd1;
	localparam logic [1:0] MODE_UNMAP  = 2'd2;

	localparam logic       REG_FIVE_LEVEL = 1'b0;
	localparam logic       REG_TABLE_BASE = 1'b1;

	localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
	localparam int          IDX_BITS  = 9;

	// datapath commands from the controller
	typedef struct packed {
		logic load;      // latch the new transaction
		logic clr_wr;    // write zero at clear pointer
		logic rd;        // read entry at walk position
		logic ev;        // evaluate read data of walk level
		logic zero_wr;   // zero a word of a new table
		logic link_wr;   // link a new table
		logic leaf_rd;   // read leaf entry
		logic leaf_ev;   // evaluate leaf entry
		logic next_page; // advance to next page of a run
		logic finish;    // emit result
	} ptw_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic       badarg;
		logic       is_lookup;
		logic       is_map;
		logic       last_level;
		logic       ent_present;
		logic       ent_bad;
		logic       store_full;
		logic       zero_done;
		logic       clr_done;
		logic       leaf_present;
		logic       last_page;
	} ptw_stat_t;
endpackage

FILE: rtl/core/ptw_ctrl.sv
// controller state machine of the page table walker
// depends on ptw_pkg and the assertion header
`timescale 1ns / 1ps
`include "page_table_walk_map_unmap_assert.svh"
module ptw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ptw_pkg::ptw_stat_t st,
	output ptw_pkg::ptw_cmd_t  cmd,
	output logic               busy
);
	typedef enum logic [10:0] {
		S_CLEAR  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_CHECK  = 11'b000_0000_0100,
		S_RD     = 11'b000_0000_1000,
		S_EV     = 11'b000_0001_0000,
		S_ZERO   = 11'b000_0010_0000,
		S_LINK   = 11'b000_0100_0000,
		S_LRD    = 11'b000_1000_0000,
		S_LEV    = 11'b001_0000_0000,
		S_DONE   = 11'b010_0000_0000,
		S_WAIT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.badarg) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else state_d = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: state_d = S_EV;
			S_EV: begin
				cmd.ev = 1'b1;
				if (st.ent_present) begin
					if (st.ent_bad) begin
						cmd.finish = 1'b1;
						state_d = S_IDLE;
					end else if (st.last_level) state_d = S_LRD;
					else state_d = S_RD;
				end else if (st.is_map) begin
					if (st.store_full) begin
						cmd.finish = 1'b1;
						state_d = S_IDLE;
					end else state_d = S_ZERO;
				end else begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ZERO: begin
				cmd.zero_wr = 1'b1;
				if (st.zero_done) state_d = S_LINK;
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
				if (st.last_level) state_d = S_LRD;
				else state_d = S_RD;
			end
			S_LRD: begin
				cmd.leaf_rd = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_LEV;
			S_LEV: begin
				cmd.leaf_ev = 1'b1;
				if (st.is_lookup) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else if (st.leaf_present == st.is_map || st.last_page) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.next_page = 1'b1;
					state_d = S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`PTW_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`PTW_ASSERT_IMP(a_fin_busy, clk, arst_n, cmd.finish, busy)
	`PTW_ASSERT_NXT(a_load_chk, clk, arst_n, cmd.load, state_q == S_CHECK)
endmodule

FILE: rtl/core/ptw_dp.sv
// datapath of the page table walker: table store, allocator, address generation
// depends on ptw_pkg and the assertion header
`timescale 1ns / 1ps
`include "page_table_walk_map_unmap_assert.svh"
module ptw_dp #(
	parameter int TABLE_FRAMES = 64,
	parameter int MAX_PAGES    = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptw_pkg::ptw_cmd_t  cmd,
	output ptw_pkg::ptw_stat_t st,
	input  logic               cfg_five,
	input  logic [39:0]        cfg_base,
	input  logic [1:0]         mode,
	input  logic [63:0]        virt_addr,
	input  logic [51:0]        phys_addr,
	input  logic [63:0]        entry_flags,
	input  logic [9:0]         page_count,
	output logic               done,
	output logic [2:0]         status,
	output logic [51:0]        translated_addr,
	output logic               is_mapped
);
	localparam int FB = (TABLE_FRAMES > 2) ? $clog2(TABLE_FRAMES) : 1;
	localparam int AB = FB + ptw_pkg::IDX_BITS;
	localparam int DEPTH = TABLE_FRAMES * 512;
	localparam int CB = $clog2(TABLE_FRAMES + 1);

	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;

	logic [1:0]  mode_q;
	logic [63:0] va_q, pa_q, flags_q;
	logic [9:0]  left_q;
	logic [2:0]  lvl_q;     // remaining levels above leaf
	logic [FB-1:0] frame_q;
	logic [CB-1:0] nff_q;
	logic [AB-1:0] clr_q;
	logic [8:0]  zcnt_q;
	logic [AB-1:0] pos_q;
	logic [63:0] local_w;
	logic [5:0]  shift_w;
	logic [8:0]  idx_w;
	logic        we;
	logic [AB-1:0] waddr;
	logic [63:0] wdata;

	assign shift_w = 6'd12 + 6'(9 * lvl_q);
	assign idx_w = 9'((va_q >> shift_w) & 64'h1FF);
	assign local_w = ((((rdata_q & ptw_pkg::ADDR_MASK) >> 12) - {24'd0, cfg_base})
		& 64'hFF_FFFF_FFFF);

	always_comb begin
		st.badarg = (mode_q == 2'd3) || ((mode_q != ptw_pkg::MODE_LOOKUP) &&
			((left_q == 10'd0) || ({22'd0, left_q} > 32'(MAX_PAGES)) ||
			(va_q[11:0] != 12'd0) ||
			((mode_q == ptw_pkg::MODE_MAP) && (pa_q[11:0] != 12'd0))));
		st.is_lookup = (mode_q == ptw_pkg::MODE_LOOKUP);
		st.is_map = (mode_q == ptw_pkg::MODE_MAP);
		st.last_level = (lvl_q == 3'd1);
		st.ent_present = rdata_q[0];
		st.ent_bad = (local_w >= 64'(nff_q)) || (local_w >= 64'(TABLE_FRAMES));
		st.store_full = (nff_q >= CB'(TABLE_FRAMES));
		st.zero_done = (zcnt_q == 9'h1FF);
		st.clr_done = (clr_q == AB'(DEPTH - 1));
		st.leaf_present = rdata_q[0];
		st.last_page = (left_q == 10'd1);
	end

	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = '0;
		priority if (cmd.clr_wr) begin
			we = 1'b1;
			waddr = clr_q;
		end else if (cmd.zero_wr) begin
			we = 1'b1;
			waddr = {nff_q[FB-1:0], zcnt_q};
		end else if (cmd.link_wr) begin
			we = 1'b1;
			wdata = {12'd0, 40'(cfg_base + 40'(nff_q)), 12'h003};
		end else if (cmd.leaf_ev && !rdata_q[0] && mode_q == ptw_pkg::MODE_MAP) begin
			we = 1'b1;
			wdata = pa_q | flags_q | 64'd1;
		end else if (cmd.leaf_ev && rdata_q[0] && mode_q == ptw_pkg::MODE_UNMAP) begin
			we = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			zcnt_q <= '0;
			nff_q <= CB'(1);
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.clr_wr) clr_q <= clr_q + AB'(1);
			if (cmd.zero_wr) zcnt_q <= zcnt_q + 9'd1;
			if (cmd.link_wr) nff_q <= nff_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			va_q <= virt_addr;
			pa_q <= {12'd0, phys_addr};
			flags_q <= entry_flags;
			left_q <= page_count;
		end
		if (cmd.load || cmd.next_page) begin
			lvl_q <= cfg_five ? 3'd4 : 3'd3;
			frame_q <= '0;
		end
		if (cmd.rd) pos_q <= {frame_q, idx_w};
		if (cmd.leaf_rd) pos_q <= {frame_q, va_q[20:12]};
		if (cmd.ev && rdata_q[0]) begin
			frame_q <= local_w[FB-1:0];
			lvl_q <= lvl_q - 3'd1;
		end
		if (cmd.link_wr) begin
			frame_q <= nff_q[FB-1:0];
			lvl_q <= lvl_q - 3'd1;
		end
		if (cmd.next_page) begin
			va_q <= va_q + 64'd4096;
			pa_q <= pa_q + 64'd4096;
			left_q <= left_q - 10'd1;
		end
		if (cmd.finish) begin
			translated_addr <= '0;
			is_mapped <= 1'b0;
			if (st.badarg && !cmd.ev && !cmd.leaf_ev) status <= ptw_pkg::ST_BADARG;
			else if (cmd.ev) begin
				if (!rdata_q[0] && mode_q == ptw_pkg::MODE_MAP && !st.ent_bad)
					status <= ptw_pkg::ST_FULL;
				else if (!rdata_q[0] && mode_q == ptw_pkg::MODE_MAP)
					status <= ptw_pkg::ST_FULL;
				else status <= ptw_pkg::ST_NOTMAPPED;
			end else if (mode_q == ptw_pkg::MODE_LOOKUP) begin
				if (rdata_q[0]) begin
					status <= ptw_pkg::ST_OK;
					translated_addr <= rdata_q[51:0] & 52'hF_FFFF_FFFF_F000
						| {40'd0, va_q[11:0]};
					is_mapped <= 1'b1;
				end else status <= ptw_pkg::ST_NOTMAPPED;
			end else if (mode_q == ptw_pkg::MODE_MAP)
				status <= rdata_q[0] ? ptw_pkg::ST_ALREADY : ptw_pkg::ST_OK;
			else status <= rdata_q[0] ? ptw_pkg::ST_OK : ptw_pkg::ST_NOTMAPPED;
		end
	end

	`PTW_ASSERT_IMP(a_nff_lim, clk, arst_n, 1'b1, nff_q <= CB'(TABLE_FRAMES))
	`PTW_ASSERT_NXT(a_link_grow, clk, arst_n, cmd.link_wr, nff_q == $past(nff_q) + CB'(1))
	`PTW_ASSERT_IMP(a_zero_map, clk, arst_n, cmd.zero_wr, mode_q == ptw_pkg::MODE_MAP)
endmodule

FILE: rtl/core/page_table_walk_map_unmap.sv
// page table walker with map and unmap; top level joining controller and datapath
// depends on ptw_pkg, ptw_ctrl, ptw_dp
// each page walks every level, then the leaf; a newly allocated table is zeroed first
// one transaction at a time
// after reset a clearing pass over all TABLE_FRAMES*512 table words runs with busy high
// the result shows for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
module page_table_walk_map_unmap #(
	parameter int TABLE_FRAMES = 64,
	parameter int MAX_PAGES    = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [63:0] virt_addr,
	input  logic [51:0] phys_addr,
	input  logic [63:0] entry_flags,
	input  logic [9:0]  page_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [39:0] cfg_wdata,
	output logic        done,
	output logic [2:0]  status,
	output logic [51:0] translated_addr,
	output logic        is_mapped
);
	ptw_pkg::ptw_cmd_t  cmd;
	ptw_pkg::ptw_stat_t st;
	logic        five_q;
	logic [39:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			five_q <= 1'b0;
			base_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ptw_pkg::REG_FIVE_LEVEL) five_q <= cfg_wdata[0];
			else base_q <= cfg_wdata;
		end
	end

	ptw_ctrl u_ctrl (.clk, .arst_n, .start, .st, .cmd, .busy);

	ptw_dp #(.TABLE_FRAMES(TABLE_FRAMES), .MAX_PAGES(MAX_PAGES)) u_dp (
		.clk, .arst_n, .cmd, .st, .cfg_five(five_q), .cfg_base(base_q),
		.mode, .virt_addr, .phys_addr, .entry_flags, .page_count,
		.done, .status, .translated_addr, .is_mapped);
endmodule
